### hdl/rcd_pkg.sv
// Shared types, widths and constants for the RSA character decryptor.
// Holds the character table and the register map; no dependencies.
package rcd_pkg;

   localparam int OPERAND_BITS   = 14;
   localparam int CNT_BITS       = $clog2(OPERAND_BITS);
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CHAR_BITS      = 8;
   localparam int REQ_DATA_BITS  = ((OPERAND_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((OPERAND_BITS + CHAR_BITS + 7) / 8) * 8;
   localparam int TABLE_SIZE     = 87;
   localparam int TABLE_IDX_BITS = $clog2(TABLE_SIZE);

   localparam logic [OPERAND_BITS-1:0] EXPONENT_RESET = OPERAND_BITS'(1);
   localparam logic [OPERAND_BITS-1:0] MODULUS_RESET  = OPERAND_BITS'(9999);
   localparam logic [OPERAND_BITS-1:0] MIN_MODULUS    = OPERAND_BITS'(2);
   localparam logic [OPERAND_BITS-1:0] OPERAND_ONE    = OPERAND_BITS'(1);

   localparam logic REG_EXPONENT = 1'b0;
   localparam logic REG_MODULUS  = 1'b1;

   localparam logic [CHAR_BITS-1:0] FILLER = 8'hA4;

   localparam logic [CHAR_BITS-1:0] CHAR_TABLE [TABLE_SIZE] = '{
      FILLER, FILLER, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
      8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
      8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h41, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c,
      8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
      8'h57, 8'h58, 8'h59, 8'h5a, 8'h2c, 8'h2e, 8'h3f, 8'h21, 8'h5f, 8'h2b,
      8'h2d, 8'h2a, 8'h2f, 8'h24, 8'h3c, 8'h3e, 8'h28, 8'h29, 8'h5b, 8'h5d,
      8'h7b, 8'h7d, 8'h3d, 8'h22, 8'h27, 8'h2d, 8'h20
   };

   typedef struct packed {
      logic [OPERAND_BITS-1:0] exponent;
      logic [OPERAND_BITS-1:0] modulus;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic [OPERAND_BITS-1:0] multiplier;
      logic [OPERAND_BITS-1:0] multiplicand;
   } mm_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [OPERAND_BITS-1:0] product;
   } mm_rsp_type;

   function automatic logic out_of_table(input logic [OPERAND_BITS-1:0] value);
      return value >= OPERAND_BITS'(TABLE_SIZE);
   endfunction

   function automatic logic [CHAR_BITS-1:0] char_lookup(
      input logic [OPERAND_BITS-1:0] value);
      if (out_of_table(value)) begin
         return '0;
      end
      return CHAR_TABLE[value[TABLE_IDX_BITS-1:0]];
   endfunction

endpackage

### hdl/rcd_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on rcd_pkg for widths and the request and response structs.
module rcd_modmul import rcd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mm_req_type              mm_req,
   input  logic [OPERAND_BITS-1:0] modulus,
   output mm_rsp_type              mm_rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [OPERAND_BITS-1:0] a_ff, a_in;
   logic [OPERAND_BITS-1:0] m_ff, m_in;
   logic [OPERAND_BITS+1:0] sum, red1, red2, m_ext;

   always_comb begin
      m_ext = {2'b00, m_ff};
      sum   = {1'b0, acc_ff, 1'b0}
            + (b_ff[OPERAND_BITS-1] ? {2'b00, a_ff} : '0);
      red1  = (sum >= m_ext) ? sum - m_ext : sum;
      red2  = (red1 >= m_ext) ? red1 - m_ext : red1;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      if (mm_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(OPERAND_BITS - 1);
         acc_in  = '0;
         b_in    = mm_req.multiplier;
         a_in    = mm_req.multiplicand;
         m_in    = modulus;
      end else if (busy_ff) begin
         acc_in = red2[OPERAND_BITS-1:0];
         b_in   = {b_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
   end

   assign mm_rsp.busy    = busy_ff;
   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = acc_ff;

endmodule

### hdl/rcd_csr.sv
// Configuration registers behind an APB-style port: exponent and modulus.
// Depends on rcd_pkg for the register map, reset values and cfg_type.
module rcd_csr import rcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [OPERAND_BITS-1:0] exponent_ff, exponent_in;
   logic [OPERAND_BITS-1:0] modulus_ff, modulus_in;
   logic                    write_en;

   always_comb begin
      write_en    = csr_psel && csr_penable && csr_pwrite;
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (write_en) begin
         unique case (csr_paddr[2])
            REG_EXPONENT: exponent_in = csr_pwdata[OPERAND_BITS-1:0];
            REG_MODULUS:  modulus_in  = csr_pwdata[OPERAND_BITS-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXPONENT_RESET;
         modulus_ff  <= MODULUS_RESET;
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXPONENT: csr_prdata = CSR_DATA_BITS'(exponent_ff);
         REG_MODULUS:  csr_prdata = CSR_DATA_BITS'(modulus_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready   = 1'b1;
   assign cfg.exponent = exponent_ff;
   assign cfg.modulus  = modulus_ff;

endmodule

### hdl/rsa_char_decrypt.sv
// Top level of the RSA character decryptor: sequencer, result register.
// Depends on rcd_pkg, rcd_csr and rcd_modmul.
//
// Each transfer on the req channel carries one ciphertext value in tdata.
// The block reduces it modulo the modulus, raises it to the exponent by
// square-and-multiply over all 14 exponent bits, MSB first, and returns on
// the rsp channel the plain value and its character code in tdata, with the
// out-of-table flag in tuser.
// All arithmetic runs through one bit-serial modular multiplier. The
// sequencer returns to idle, and so can take the next item, as the result
// is registered. A modulus below two skips the multiplier and gives a
// plain value of 0. req_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the receiver
// stalls; the sequencer then holds before writing the next result until
// that register is free. Reset clears the sequencer and the result valid,
// and sets the exponent to 1 and the modulus to 9999. Registers are to be
// written only while idle; the block itself does not enforce this.
module rsa_char_decrypt import rcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // cipher_value
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // plain_value, char_code
   output logic                     rsp_tuser,   // out_of_table
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_SQUARE,
      S_MULT,
      S_FINISH
   } state_type;

   cfg_type    cfg;
   mm_rsp_type mm_rsp;

   state_type               state_ff, state_in;
   mm_req_type              mm_req_ff, mm_req_in;
   logic [CNT_BITS-1:0]     bit_ff, bit_in;
   logic [OPERAND_BITS-1:0] base_ff, base_in;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] rsp_plain_ff, rsp_plain_in;
   logic [CHAR_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                    rsp_oot_ff, rsp_oot_in;

   rcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcd_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .mm_req  (mm_req_ff),
      .modulus (cfg.modulus),
      .mm_rsp  (mm_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      mm_req_in    = mm_req_ff;
      mm_req_in.start = 1'b0;
      bit_in       = bit_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_plain_in = rsp_plain_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_oot_in   = rsp_oot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (cfg.modulus < MIN_MODULUS) begin
                  acc_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  mm_req_in = '{1'b1, req_tdata[OPERAND_BITS-1:0], OPERAND_ONE};
                  state_in  = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mm_rsp.done) begin
               base_in   = mm_rsp.product;
               acc_in    = OPERAND_ONE;
               bit_in    = CNT_BITS'(OPERAND_BITS - 1);
               mm_req_in = '{1'b1, OPERAND_ONE, OPERAND_ONE};
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (cfg.exponent[bit_ff]) begin
                  mm_req_in = '{1'b1, mm_rsp.product, base_ff};
                  state_in  = S_MULT;
               end else if (bit_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  bit_in    = bit_ff - CNT_BITS'(1);
                  mm_req_in = '{1'b1, mm_rsp.product, mm_rsp.product};
               end
            end
         end
         S_MULT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (bit_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  bit_in    = bit_ff - CNT_BITS'(1);
                  mm_req_in = '{1'b1, mm_rsp.product, mm_rsp.product};
                  state_in  = S_SQUARE;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_plain_in = acc_ff;
               rsp_char_in  = char_lookup(acc_ff);
               rsp_oot_in   = out_of_table(acc_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mm_req_ff.start <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mm_req_ff.start <= mm_req_in.start;
         rsp_valid_ff    <= rsp_valid_in;
      end
      mm_req_ff.multiplier   <= mm_req_in.multiplier;
      mm_req_ff.multiplicand <= mm_req_in.multiplicand;
      bit_ff       <= bit_in;
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      rsp_plain_ff <= rsp_plain_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_oot_ff   <= rsp_oot_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_char_ff, rsp_plain_ff});
   assign rsp_tuser  = rsp_oot_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted transfer");

   a_done_in_compute: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == S_REDUCE || state_ff == S_SQUARE ||
                       state_ff == S_MULT))
      else $error("multiplier finished outside a compute state");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mm_req_ff.start |-> !mm_rsp.busy)
      else $error("multiplier started while still busy");

   a_oot_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oot_ff |-> rsp_char_ff == '0)
      else $error("out-of-table result carries a nonzero character code");
`endif

endmodule
